/* rtl/core/scr_pkg.sv */
// ============================================================================
// Spherical coordinate rotation package
// Shared widths, angle constants, function codes, sideband types and the
// CORDIC arctangent table.
// ============================================================================
package scr_pkg;

   // Datapath widths of the CORDIC x/y and angle (z) channels.
   localparam int XW = 36;
   localparam int ZW = 34;

   // Function codes of an input transaction.
   localparam logic [1:0] FUNC_DIRECT  = 2'd0;
   localparam logic [1:0] FUNC_INVERSE = 2'd1;
   localparam logic [1:0] FUNC_LOAD    = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   // Matrix index code that lies outside the 3x3 matrix.
   localparam logic [1:0] IDX_INVALID = 2'd3;

   // Angles in Q10.22 degrees.
   localparam logic signed [ZW-1:0] DEG90  = ZW'(377487360);
   localparam logic signed [ZW-1:0] DEG180 = ZW'(754974720);
   localparam logic signed [ZW-1:0] DEG270 = ZW'(1132462080);
   localparam logic signed [ZW-1:0] DEG360 = ZW'(1509949440);

   // 1.0 in Q2.30 and the inverse CORDIC gain in Q2.30.
   localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
   localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         coef_row;
      logic [1:0]         coef_col;
      logic signed [31:0] coef_value;
   } meta_type;

   typedef struct packed {
      meta_type meta;
      logic     neg_lon;
      logic     neg_lat;
   } rot_side_type;

   // Carried beside a vectoring pipeline: an angle or a component to keep.
   typedef struct packed {
      logic                  degenerate;
      logic signed [ZW-1:0]  carry;
   } vec_side_type;

   // atan(2^-i) in Q10.22 degrees.
   function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:    r = ZW'(188743680);
         5'd1:    r = ZW'(111421900);
         5'd2:    r = ZW'(58872272);
         5'd3:    r = ZW'(29884485);
         5'd4:    r = ZW'(15000234);
         5'd5:    r = ZW'(7507429);
         5'd6:    r = ZW'(3754631);
         5'd7:    r = ZW'(1877430);
         5'd8:    r = ZW'(938729);
         5'd9:    r = ZW'(469366);
         5'd10:   r = ZW'(234683);
         5'd11:   r = ZW'(117342);
         5'd12:   r = ZW'(58671);
         5'd13:   r = ZW'(29335);
         5'd14:   r = ZW'(14668);
         5'd15:   r = ZW'(7334);
         5'd16:   r = ZW'(3667);
         5'd17:   r = ZW'(1833);
         5'd18:   r = ZW'(917);
         5'd19:   r = ZW'(458);
         5'd20:   r = ZW'(229);
         5'd21:   r = ZW'(115);
         5'd22:   r = ZW'(57);
         5'd23:   r = ZW'(29);
         5'd24:   r = ZW'(14);
         5'd25:   r = ZW'(7);
         5'd26:   r = ZW'(4);
         5'd27:   r = ZW'(2);
         5'd28:   r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/scr_rot_stage.sv */
// ============================================================================
// CORDIC rotation stage
// One registered micro-rotation that drives the angle residue toward zero.
// ============================================================================
module scr_rot_stage #(
   parameter int STAGE = 0
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [scr_pkg::XW-1:0]     x_src,
   input  logic signed [scr_pkg::XW-1:0]     y_src,
   input  logic signed [scr_pkg::ZW-1:0]     z_src,
   output logic signed [scr_pkg::XW-1:0]     x_ff,
   output logic signed [scr_pkg::XW-1:0]     y_ff,
   output logic signed [scr_pkg::ZW-1:0]     z_ff
);

   logic signed [scr_pkg::XW-1:0] dx, dy, x_in, y_in;
   logic signed [scr_pkg::ZW-1:0] ang, z_in;

   always_comb begin
      ang = scr_pkg::atan_deg(5'(STAGE));
      // Floor shifts: the arithmetic shift rounds toward minus infinity.
      dx  = y_src >>> STAGE;
      dy  = x_src >>> STAGE;
      if (z_src >= 0) begin
         x_in = x_src - dx;
         y_in = y_src + dy;
         z_in = z_src - ang;
      end else begin
         x_in = x_src + dx;
         y_in = y_src - dy;
         z_in = z_src + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

/* rtl/core/scr_vec_stage.sv */
// ============================================================================
// CORDIC vectoring stage
// One registered micro-rotation that drives the y component toward zero.
// ============================================================================
module scr_vec_stage #(
   parameter int STAGE = 0
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [scr_pkg::XW-1:0]     x_src,
   input  logic signed [scr_pkg::XW-1:0]     y_src,
   input  logic signed [scr_pkg::ZW-1:0]     z_src,
   output logic signed [scr_pkg::XW-1:0]     x_ff,
   output logic signed [scr_pkg::XW-1:0]     y_ff,
   output logic signed [scr_pkg::ZW-1:0]     z_ff
);

   logic signed [scr_pkg::XW-1:0] dx, dy, x_in, y_in;
   logic signed [scr_pkg::ZW-1:0] ang, z_in;

   always_comb begin
      dx  = y_src >>> STAGE;
      dy  = x_src >>> STAGE;
      ang = scr_pkg::atan_deg(5'(STAGE));
      if (y_src >= 0) begin
         x_in = x_src + dx;
         y_in = y_src - dy;
         z_in = z_src + ang;
      end else begin
         x_in = x_src - dx;
         y_in = y_src + dy;
         z_in = z_src - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

/* rtl/core/scr_matmul.sv */
// ============================================================================
// Unit vector and matrix product
// Three stages: unit vector products, nine coefficient products, and the
// rounded row sums. Holds the 3x3 coefficient matrix, written in stream order.
// ============================================================================
module scr_matmul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              vld_src,
   input  scr_pkg::rot_side_type             side_src,
   input  logic signed [scr_pkg::XW-1:0]     cos_lon,
   input  logic signed [scr_pkg::XW-1:0]     sin_lon,
   input  logic signed [scr_pkg::XW-1:0]     cos_lat,
   input  logic signed [scr_pkg::XW-1:0]     sin_lat,
   output logic                              vld_ff,
   output logic signed [31:0]                v_ff [3]
);

   localparam int PW = 2 * scr_pkg::XW;

   // Unit vector stage.
   logic signed [scr_pkg::XW-1:0] cl, sl, cp, sp;
   logic signed [PW-1:0]          pcc, psc;
   logic signed [31:0]            u_in [3];
   logic signed [31:0]            u_ff [3];
   logic                          ma_vld_ff;
   scr_pkg::meta_type             ma_meta_ff;

   always_comb begin
      cl = side_src.neg_lon ? -cos_lon : cos_lon;
      sl = side_src.neg_lon ? -sin_lon : sin_lon;
      cp = side_src.neg_lat ? -cos_lat : cos_lat;
      sp = side_src.neg_lat ? -sin_lat : sin_lat;
      pcc = PW'(cl) * PW'(cp);
      psc = PW'(sl) * PW'(cp);
      u_in[0] = 32'((pcc + PW'(536870912)) >>> 30);
      u_in[1] = 32'((psc + PW'(536870912)) >>> 30);
      u_in[2] = 32'(sp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ma_vld_ff <= 1'b0;
      end else if (en) begin
         ma_vld_ff <= vld_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_meta_ff <= side_src.meta;
         u_ff       <= u_in;
      end
   end

   // Coefficient matrix, row * 3 + col. A load writes it as it passes this
   // stage, so a rotation behind it sees the new value and one ahead does not.
   logic signed [31:0] coef_ff [9];
   logic [3:0]         wr_idx;
   logic               wr_en;

   assign wr_idx = 4'(ma_meta_ff.coef_row) * 4'd3 + 4'(ma_meta_ff.coef_col);
   assign wr_en  = en && ma_vld_ff && (ma_meta_ff.func == scr_pkg::FUNC_LOAD)
                   && (ma_meta_ff.coef_row != scr_pkg::IDX_INVALID)
                   && (ma_meta_ff.coef_col != scr_pkg::IDX_INVALID);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 9; j++) begin
            coef_ff[j] <= (j % 4 == 0) ? scr_pkg::ONE_Q30 : '0;
         end
      end else if (wr_en) begin
         coef_ff[wr_idx] <= ma_meta_ff.coef_value;
      end
   end

   // Coefficient product stage.
   logic signed [63:0] prod_in [9];
   logic signed [63:0] prod_ff [9];
   logic               mb_vld_ff;
   logic signed [31:0] m_sel;

   always_comb begin
      m_sel = '0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            m_sel = (ma_meta_ff.func == scr_pkg::FUNC_INVERSE) ? coef_ff[i*3+k]
                                                               : coef_ff[k*3+i];
            prod_in[i*3+k] = 64'(m_sel) * 64'(u_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mb_vld_ff <= 1'b0;
      end else if (en) begin
         mb_vld_ff <= ma_vld_ff && (ma_meta_ff.func != scr_pkg::FUNC_LOAD);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // Row sums in Q.60, rounded to Q.28.
   logic signed [65:0] acc [3];
   logic signed [31:0] v_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = 66'(prod_ff[i*3]) + 66'(prod_ff[i*3+1]) + 66'(prod_ff[i*3+2])
                  + 66'sd2147483648;
         v_in[i] = 32'(acc[i] >>> 32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= mb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

endmodule

/* rtl/core/spherical_coordinate_rotation_top.sv */
// ============================================================================
// Spherical coordinate rotation
// Rotates longitude/latitude pairs through a stored 3x3 matrix, fully
// pipelined with unrolled CORDIC stages.
// ============================================================================
// The block accepts one transaction per clock while the pipeline does not
// hold, and returns the rotated points in stream order. The pipeline is built
// from three unrolled CORDIC pipelines in series: a rotation pair for sine and
// cosine of both input angles, a vectoring pass for the longitude and a
// vectoring pass for the latitude, plus the input reduction stage, three
// matrix stages, the gain multiply and the output register. All stages
// advance together; when a result waits in the output register and rsp_ready
// is low, the whole pipeline holds and req_ready drops, so nothing is lost or
// repeated. A load transaction writes its coefficient when it reaches the
// matrix stage, so it takes effect exactly between the rotations that
// surround it in the stream, and it produces no response. A transaction with
// the unused function code is dropped on entry. A zero rotated vector returns
// zero angles with the degenerate flag set.
module spherical_coordinate_rotation_top #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic signed [31:0]  req_lon_in,
   input  logic signed [31:0]  req_lat_in,
   input  logic [1:0]          req_coef_row,
   input  logic [1:0]          req_coef_col,
   input  logic signed [31:0]  req_coef_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [30:0]  rsp_lon_out,
   output logic signed [29:0]  rsp_lat_out,
   output logic                rsp_degenerate
);

   localparam int XW = scr_pkg::XW;
   localparam int ZW = scr_pkg::ZW;
   localparam int GW = XW + 32;

   typedef struct packed {
      logic                 neg;
      logic signed [ZW-1:0] ang;
   } fold_type;

   // The pipeline moves as one; it holds only while a result is not taken.
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Reduce an angle modulo 360 degrees and fold it into [-90, 90]. With
   // t = angle + 180 taken into [0, 360), the angle lies beyond +-90 exactly
   // when t is below 90 or above 270.
   function automatic fold_type reduce_fold(input logic signed [31:0] a);
      logic signed [ZW-1:0] t0, t;
      fold_type             r;
      t0 = ZW'(a) + scr_pkg::DEG180;
      if (t0 < 0) begin
         t = t0 + scr_pkg::DEG360;
      end else if (t0 >= scr_pkg::DEG360) begin
         t = t0 - scr_pkg::DEG360;
      end else begin
         t = t0;
      end
      if (t < scr_pkg::DEG90) begin
         r.neg = 1'b1;
         r.ang = t;
      end else if (t > scr_pkg::DEG270) begin
         r.neg = 1'b1;
         r.ang = t - scr_pkg::DEG360;
      end else begin
         r.neg = 1'b0;
         r.ang = t - scr_pkg::DEG180;
      end
      return r;
   endfunction

   // Input stage: angle reduction and the transaction's sideband.
   fold_type               lon_fold, lat_fold;
   logic                   s0_vld_ff;
   scr_pkg::rot_side_type  s0_side_ff;
   logic signed [ZW-1:0]   s0_lon_ff, s0_lat_ff;

   assign lon_fold = reduce_fold(req_lon_in);
   assign lat_fold = reduce_fold(req_lat_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_valid && (req_func != scr_pkg::FUNC_UNUSED);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_side_ff.meta.func       <= req_func;
         s0_side_ff.meta.coef_row   <= req_coef_row;
         s0_side_ff.meta.coef_col   <= req_coef_col;
         s0_side_ff.meta.coef_value <= req_coef_value;
         s0_side_ff.neg_lon         <= lon_fold.neg;
         s0_side_ff.neg_lat         <= lat_fold.neg;
         s0_lon_ff                  <= lon_fold.ang;
         s0_lat_ff                  <= lat_fold.ang;
      end
   end

   // Rotation CORDIC for sine and cosine of both angles.
   logic signed [XW-1:0]  rot_lx [CORDIC_STAGES+1];
   logic signed [XW-1:0]  rot_ly [CORDIC_STAGES+1];
   logic signed [ZW-1:0]  rot_lz [CORDIC_STAGES+1];
   logic signed [XW-1:0]  rot_px [CORDIC_STAGES+1];
   logic signed [XW-1:0]  rot_py [CORDIC_STAGES+1];
   logic signed [ZW-1:0]  rot_pz [CORDIC_STAGES+1];
   logic                  rot_vld [CORDIC_STAGES+1];
   scr_pkg::rot_side_type rot_side [CORDIC_STAGES+1];

   assign rot_lx[0]   = XW'(scr_pkg::INV_GAIN);
   assign rot_ly[0]   = '0;
   assign rot_lz[0]   = s0_lon_ff;
   assign rot_px[0]   = XW'(scr_pkg::INV_GAIN);
   assign rot_py[0]   = '0;
   assign rot_pz[0]   = s0_lat_ff;
   assign rot_vld[0]  = s0_vld_ff;
   assign rot_side[0] = s0_side_ff;

   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
      logic                  vld_ff;
      scr_pkg::rot_side_type side_ff;

      scr_rot_stage #(.STAGE(gi)) u_lon (
         .clock (clock), .en (en),
         .x_src (rot_lx[gi]), .y_src (rot_ly[gi]), .z_src (rot_lz[gi]),
         .x_ff  (rot_lx[gi+1]), .y_ff (rot_ly[gi+1]), .z_ff (rot_lz[gi+1])
      );

      scr_rot_stage #(.STAGE(gi)) u_lat (
         .clock (clock), .en (en),
         .x_src (rot_px[gi]), .y_src (rot_py[gi]), .z_src (rot_pz[gi]),
         .x_ff  (rot_px[gi+1]), .y_ff (rot_py[gi+1]), .z_ff (rot_pz[gi+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= rot_vld[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= rot_side[gi];
         end
      end

      assign rot_vld[gi+1]  = vld_ff;
      assign rot_side[gi+1] = side_ff;
   end

   // Unit vector, matrix product and coefficient storage.
   logic               mc_vld;
   logic signed [31:0] mc_v [3];

   scr_matmul u_matmul (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_src  (rot_vld[CORDIC_STAGES]),
      .side_src (rot_side[CORDIC_STAGES]),
      .cos_lon  (rot_lx[CORDIC_STAGES]),
      .sin_lon  (rot_ly[CORDIC_STAGES]),
      .cos_lat  (rot_px[CORDIC_STAGES]),
      .sin_lat  (rot_py[CORDIC_STAGES]),
      .vld_ff   (mc_vld),
      .v_ff     (mc_v)
   );

   // Longitude vectoring. A vector in the left half plane is turned by 180
   // degrees first and the angle starts at +180 or -180.
   logic signed [XW-1:0]  v1_xs, v1_ys, v1_x0, v1_y0;
   logic signed [ZW-1:0]  v1_z0;
   scr_pkg::vec_side_type v1_side0;

   always_comb begin
      v1_xs = XW'(mc_v[0]);
      v1_ys = XW'(mc_v[1]);
      if (v1_xs < 0) begin
         v1_x0 = -v1_xs;
         v1_y0 = -v1_ys;
         v1_z0 = (v1_ys >= 0) ? scr_pkg::DEG180 : -scr_pkg::DEG180;
      end else begin
         v1_x0 = v1_xs;
         v1_y0 = v1_ys;
         v1_z0 = '0;
      end
      v1_side0.degenerate = (mc_v[0] == '0) && (mc_v[1] == '0) && (mc_v[2] == '0);
      v1_side0.carry      = ZW'(mc_v[2]);
   end

   logic signed [XW-1:0]  v1_x [CORDIC_STAGES+1];
   logic signed [XW-1:0]  v1_y [CORDIC_STAGES+1];
   logic signed [ZW-1:0]  v1_z [CORDIC_STAGES+1];
   logic                  v1_vld [CORDIC_STAGES+1];
   scr_pkg::vec_side_type v1_side [CORDIC_STAGES+1];

   assign v1_x[0]    = v1_x0;
   assign v1_y[0]    = v1_y0;
   assign v1_z[0]    = v1_z0;
   assign v1_vld[0]  = mc_vld;
   assign v1_side[0] = v1_side0;

   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec1
      logic                  vld_ff;
      scr_pkg::vec_side_type side_ff;

      scr_vec_stage #(.STAGE(gi)) u_stage (
         .clock (clock), .en (en),
         .x_src (v1_x[gi]), .y_src (v1_y[gi]), .z_src (v1_z[gi]),
         .x_ff  (v1_x[gi+1]), .y_ff (v1_y[gi+1]), .z_ff (v1_z[gi+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= v1_vld[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= v1_side[gi];
         end
      end

      assign v1_vld[gi+1]  = vld_ff;
      assign v1_side[gi+1] = side_ff;
   end

   // Gain correction of the horizontal magnitude.
   logic                 mg_vld_ff;
   logic signed [GW-1:0] mg_prod_ff;
   logic signed [ZW-1:0] mg_lon_ff;
   logic signed [ZW-1:0] mg_z_ff;
   logic                 mg_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mg_vld_ff <= 1'b0;
      end else if (en) begin
         mg_vld_ff <= v1_vld[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mg_prod_ff  <= GW'(v1_x[CORDIC_STAGES]) * GW'(scr_pkg::INV_GAIN);
         mg_lon_ff   <= v1_z[CORDIC_STAGES];
         mg_z_ff     <= v1_side[CORDIC_STAGES].carry;
         mg_degen_ff <= v1_side[CORDIC_STAGES].degenerate;
      end
   end

   // Latitude vectoring of (gain-corrected magnitude, z component).
   logic signed [XW-1:0]  v2_xs, v2_ys, v2_x0, v2_y0;
   logic signed [ZW-1:0]  v2_z0;
   scr_pkg::vec_side_type v2_side0;

   always_comb begin
      v2_xs = XW'((mg_prod_ff + GW'(536870912)) >>> 30);
      v2_ys = XW'(mg_z_ff);
      if (v2_xs < 0) begin
         v2_x0 = -v2_xs;
         v2_y0 = -v2_ys;
         v2_z0 = (v2_ys >= 0) ? scr_pkg::DEG180 : -scr_pkg::DEG180;
      end else begin
         v2_x0 = v2_xs;
         v2_y0 = v2_ys;
         v2_z0 = '0;
      end
      v2_side0.degenerate = mg_degen_ff;
      v2_side0.carry      = mg_lon_ff;
   end

   logic signed [XW-1:0]  v2_x [CORDIC_STAGES+1];
   logic signed [XW-1:0]  v2_y [CORDIC_STAGES+1];
   logic signed [ZW-1:0]  v2_z [CORDIC_STAGES+1];
   logic                  v2_vld [CORDIC_STAGES+1];
   scr_pkg::vec_side_type v2_side [CORDIC_STAGES+1];

   assign v2_x[0]    = v2_x0;
   assign v2_y[0]    = v2_y0;
   assign v2_z[0]    = v2_z0;
   assign v2_vld[0]  = mg_vld_ff;
   assign v2_side[0] = v2_side0;

   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec2
      logic                  vld_ff;
      scr_pkg::vec_side_type side_ff;

      scr_vec_stage #(.STAGE(gi)) u_stage (
         .clock (clock), .en (en),
         .x_src (v2_x[gi]), .y_src (v2_y[gi]), .z_src (v2_z[gi]),
         .x_ff  (v2_x[gi+1]), .y_ff (v2_y[gi+1]), .z_ff (v2_z[gi+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= v2_vld[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= v2_side[gi];
         end
      end

      assign v2_vld[gi+1]  = vld_ff;
      assign v2_side[gi+1] = side_ff;
   end

   // Output register: saturate the CORDIC residue and apply the zero-vector
   // case.
   logic signed [ZW-1:0] lon_raw, lat_raw, lon_sat, lat_sat;
   logic                 degen_last;
   logic signed [30:0]   rsp_lon_out_ff, rsp_lon_out_in;
   logic signed [29:0]   rsp_lat_out_ff, rsp_lat_out_in;
   logic                 rsp_degenerate_ff;

   always_comb begin
      lon_raw    = v2_side[CORDIC_STAGES].carry;
      lat_raw    = v2_z[CORDIC_STAGES];
      degen_last = v2_side[CORDIC_STAGES].degenerate;
      if (lon_raw > scr_pkg::DEG180) begin
         lon_sat = scr_pkg::DEG180;
      end else if (lon_raw < -scr_pkg::DEG180) begin
         lon_sat = -scr_pkg::DEG180;
      end else begin
         lon_sat = lon_raw;
      end
      if (lat_raw > scr_pkg::DEG90) begin
         lat_sat = scr_pkg::DEG90;
      end else if (lat_raw < -scr_pkg::DEG90) begin
         lat_sat = -scr_pkg::DEG90;
      end else begin
         lat_sat = lat_raw;
      end
      rsp_lon_out_in = degen_last ? '0 : 31'(lon_sat);
      rsp_lat_out_in = degen_last ? '0 : 30'(lat_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v2_vld[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_lon_out_ff    <= rsp_lon_out_in;
         rsp_lat_out_ff    <= rsp_lat_out_in;
         rsp_degenerate_ff <= degen_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lon_out    = rsp_lon_out_ff;
   assign rsp_lat_out    = rsp_lat_out_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

`ifndef ASSERT_OFF
   // A degenerate response carries zero angles.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_degenerate_ff |-> rsp_lon_out_ff == '0 && rsp_lat_out_ff == '0)
      else $error("degenerate response with nonzero angles");

   // Saturation keeps the angles inside their ranges.
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (ZW'(rsp_lon_out_ff) <= scr_pkg::DEG180)
                    && (ZW'(rsp_lon_out_ff) >= -scr_pkg::DEG180)
                    && (ZW'(rsp_lat_out_ff) <= scr_pkg::DEG90)
                    && (ZW'(rsp_lat_out_ff) >= -scr_pkg::DEG90))
      else $error("response angle out of range");

   // No response can be presented right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid after reset");
`endif

endmodule
